@@ src/slu_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// slu_pkg: slope limiter shared definitions
// Widths of the fixed-point datapath, mode and status codes, the divider cell
// payload and the saturating conversion from magnitude to word.
// ----------------------------------------------------------------------------
package slu_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int EPS_WIDTH  = 17;
  localparam int MODE_WIDTH = 3;
  localparam int ST_WIDTH   = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // quotient bits: every limiter form stays below 2.0
  localparam int QB   = FRAC_BITS + 2;
  localparam int PW   = 2 * DATA_WIDTH;
  localparam int EFW  = EPS_WIDTH + FRAC_BITS;
  localparam int SUMW = ((PW + 1 > EFW) ? PW + 1 : EFW) + 1;
  localparam int NW   = (SUMW + FRAC_BITS > DATA_WIDTH + 2 * FRAC_BITS + 2) ?
                        SUMW + FRAC_BITS : DATA_WIDTH + 2 * FRAC_BITS + 2;
  localparam int DENW = (SUMW + 1 > 2 * FRAC_BITS + 3) ? SUMW + 1 : 2 * FRAC_BITS + 3;
  localparam int RW   = DENW + QB;
  localparam int EW   = ((QB > DATA_WIDTH) ? QB : DATA_WIDTH) + 1;

  typedef enum logic [MODE_WIDTH-1:0] {
    MODE_ONE       = 3'd0,
    MODE_VANALB_R  = 3'd1,
    MODE_HKOREN    = 3'd2,
    MODE_MINMOD_R  = 3'd3,
    MODE_VANLEER   = 3'd4,
    MODE_MIN       = 3'd5,
    MODE_MINMOD_AB = 3'd6,
    MODE_VANALB_AB = 3'd7
  } mode_t;

  localparam logic [ST_WIDTH-1:0] ST_OK   = 2'd0;
  localparam logic [ST_WIDTH-1:0] ST_SAT  = 2'd1;
  localparam logic [ST_WIDTH-1:0] ST_ZDIV = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EPS  = 4'd1;

  typedef struct packed {
    logic [RW-1:0]         rem;
    logic [DENW-1:0]       den;
    logic [QB-1:0]         quo;
    logic                  neg;
    logic                  fixed;
    logic [DATA_WIDTH-1:0] fval;
    logic [ST_WIDTH-1:0]   fst;
  } cell_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] value;
    logic [ST_WIDTH-1:0]   status;
  } res_t;

  function automatic res_t emit(input logic neg, input logic [EW-1:0] mag);
    logic [EW-1:0] maxpos;
    logic [EW-1:0] maxneg;
    logic [EW-1:0] negmag;
    res_t r;
    maxpos = {{(EW - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
    maxneg = maxpos + EW'(1);
    negmag = ~mag + EW'(1);
    r.status = ST_OK;
    if (!neg) begin
      if (mag > maxpos) begin
        r.value  = maxpos[DATA_WIDTH-1:0];
        r.status = ST_SAT;
      end else begin
        r.value = mag[DATA_WIDTH-1:0];
      end
    end else begin
      if (mag > maxneg) begin
        r.value  = maxneg[DATA_WIDTH-1:0];
        r.status = ST_SAT;
      end else begin
        r.value = negmag[DATA_WIDTH-1:0];
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ src/slu_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// slu_if: slope limiter channels
// Request channel, result channel and register write channel, each with
// valid/ready handshake.
// ----------------------------------------------------------------------------
interface slu_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [slu_pkg::DATA_WIDTH-1:0] first_value;
  logic signed [slu_pkg::DATA_WIDTH-1:0] second_value;
  modport source(output valid, first_value, second_value, input ready);
  modport sink(input valid, first_value, second_value, output ready);
endinterface

interface slu_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [slu_pkg::DATA_WIDTH-1:0] limited_value;
  logic        [slu_pkg::ST_WIDTH-1:0]   status;
  modport source(output valid, limited_value, status, input ready);
  modport sink(input valid, limited_value, status, output ready);
endinterface

interface slu_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [slu_pkg::CFG_IDX_W-1:0]     index;
  logic [slu_pkg::CFG_DATA_W-1:0]    data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ src/slu_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// slu_front: operand preparation
// Three stages: magnitudes, products, then numerator and denominator of the
// selected form, or the final result for forms that need no division.
// ----------------------------------------------------------------------------
module slu_front (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire slu_pkg::mode_t                     mode,
  input  wire logic [slu_pkg::EPS_WIDTH-1:0]      eps,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [slu_pkg::DATA_WIDTH-1:0]     a,
  input  wire logic [slu_pkg::DATA_WIDTH-1:0]     b,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output slu_pkg::cell_t                          out_data
);

  localparam int W  = slu_pkg::DATA_WIDTH;
  localparam int F  = slu_pkg::FRAC_BITS;
  localparam int SW = slu_pkg::SUMW;
  localparam int NW = slu_pkg::NW;
  localparam int DW = slu_pkg::DENW;
  localparam int EW = slu_pkg::EW;

  logic ld0, ld1, ld2;
  logic v0, v1, v2;
  logic [W-1:0] a0, b0, ma0, mb0;
  logic [W-1:0] a1, b1, ma1, mb1;
  logic [slu_pkg::PW-1:0] pa1, pb1, pab1;
  slu_pkg::cell_t c2, c2_next;

  assign ld2 = !v2 || out_ready;
  assign ld1 = !v1 || ld2;
  assign ld0 = !v0 || ld1;
  assign in_ready = ld0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (ld0) v0 <= in_valid;
      if (ld1) v1 <= v0;
      if (ld2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ld0) begin
      a0  <= a;
      b0  <= b;
      ma0 <= a[W-1] ? ~a + W'(1) : a;
      mb0 <= b[W-1] ? ~b + W'(1) : b;
    end
    if (ld1) begin
      a1   <= a0;
      b1   <= b0;
      ma1  <= ma0;
      mb1  <= mb0;
      pa1  <= ma0 * ma0;
      pb1  <= mb0 * mb0;
      pab1 <= ma0 * mb0;
    end
    if (ld2) c2 <= c2_next;
  end

  logic          an, bn, opp, pge, less;
  logic [SW-1:0] ef, p, den7, num7;
  logic [DW-1:0] den1, den2, den4;
  logic [NW-1:0] num1, num2, num4, num7s;
  logic [EW-1:0] one_mag, ma_e;
  slu_pkg::res_t r;

  always_comb begin
    an      = a1[W-1];
    bn      = b1[W-1];
    one_mag = EW'(1) << F;
    ma_e    = EW'(ma1);
    ef      = SW'({eps, {F{1'b0}}});
    p       = SW'({pab1, 1'b0});
    den7    = SW'(pa1) + SW'(pb1) + ef;
    opp     = (ma1 != '0) && (mb1 != '0) && (an != bn);
    pge     = p >= ef;
    num7    = opp ? ef - p : ef + p;
    num7s   = NW'(num7) << F;
    den1    = DW'(pa1) + (DW'(1) << (2 * F));
    den2    = (DW'(pa1) << 1) + (DW'(1) << (2 * F + 1));
    den2    = an ? den2 + (DW'(ma1) << F) : den2 - (DW'(ma1) << F);
    num1    = NW'(ma1) << (2 * F + 1);
    num2    = ((NW'(ma1) << 1) + NW'(ma1)) << (2 * F);
    num4    = NW'(ma1) << (F + 1);
    den4    = DW'(ma1) + (DW'(1) << F);
    less    = $signed(a1) < $signed(b1);
    r       = slu_pkg::emit(1'b0, one_mag);

    c2_next       = '0;
    c2_next.fixed = 1'b1;
    c2_next.fst   = slu_pkg::ST_OK;
    unique case (mode)
      slu_pkg::MODE_ONE: begin
        c2_next.fval = r.value;
        c2_next.fst  = r.status;
      end
      slu_pkg::MODE_VANALB_R: begin
        c2_next.fixed = 1'b0;
        c2_next.neg   = an;
        c2_next.rem   = slu_pkg::RW'(num1);
        c2_next.den   = den1;
      end
      slu_pkg::MODE_HKOREN: begin
        c2_next.fixed = 1'b0;
        c2_next.neg   = an;
        c2_next.rem   = slu_pkg::RW'(num2);
        c2_next.den   = den2;
      end
      slu_pkg::MODE_MINMOD_R: begin
        if (!an) begin
          r = slu_pkg::emit(1'b0, (ma_e > one_mag) ? one_mag : ma_e);
          c2_next.fval = r.value;
          c2_next.fst  = r.status;
        end
      end
      slu_pkg::MODE_VANLEER: begin
        if (!an && ma1 != '0) begin
          c2_next.fixed = 1'b0;
          c2_next.rem   = slu_pkg::RW'(num4);
          c2_next.den   = den4;
        end
      end
      slu_pkg::MODE_MIN: begin
        c2_next.fval = less ? a1 : b1;
      end
      slu_pkg::MODE_MINMOD_AB: begin
        if (!opp) c2_next.fval = (ma1 <= mb1) ? a1 : b1;
      end
      slu_pkg::MODE_VANALB_AB: begin
        if (den7 == '0) begin
          c2_next.fst = slu_pkg::ST_ZDIV;
        end else if (!(opp && pge)) begin
          c2_next.fixed = 1'b0;
          c2_next.rem   = slu_pkg::RW'(num7s);
          c2_next.den   = DW'(den7);
        end
      end
    endcase
  end

  assign out_valid = v2;
  assign out_data  = c2;

endmodule
`default_nettype wire

@@ src/slu_div_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// slu_div_cell: one restoring division cell
// Compares the remainder with the shifted divisor, takes one quotient bit and
// hands the doubled remainder to the next cell.
// ----------------------------------------------------------------------------
module slu_div_cell (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire slu_pkg::cell_t in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output slu_pkg::cell_t      out_data
);

  localparam int RW = slu_pkg::RW;
  localparam int QB = slu_pkg::QB;

  logic           v;
  logic           ld;
  logic [RW:0]    diff;
  slu_pkg::cell_t c, c_next;

  assign ld       = !v || out_ready;
  assign in_ready = ld;

  always_comb begin
    diff   = {1'b0, in_data.rem} - ({1'b0, RW'(in_data.den)} << (QB - 1));
    c_next = in_data;
    if (!diff[RW]) begin
      c_next.rem = diff[RW-1:0] << 1;
      c_next.quo = {in_data.quo[QB-2:0], 1'b1};
    end else begin
      c_next.rem = in_data.rem << 1;
      c_next.quo = {in_data.quo[QB-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v <= 1'b0;
    else if (ld) v <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (ld) c <= c_next;
  end

  assign out_valid = v;
  assign out_data  = c;

endmodule
`default_nettype wire

@@ src/slope_limiter_unit_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// slope_limiter_unit_core: TVD slope limiter
// Q15.16 limiter with eight selectable forms and saturating result.
// ----------------------------------------------------------------------------
// One request is taken every cycle when the result side keeps up; each passes
// through three preparation stages, a chain of 18 division cells producing one
// quotient bit each, and the output register. Every stage fills when empty, so a
// stalled result does not block requests until the chain is full. Register
// writes complete at once and are meant for an idle unit.
module slope_limiter_unit_core (
  input  wire logic  clk,
  input  wire logic  rst,
  slu_in_if.sink     item,
  slu_out_if.source  result,
  slu_cfg_if.sink    cfg
);

  localparam int QB = slu_pkg::QB;
  localparam int EW = slu_pkg::EW;

  slu_pkg::mode_t                  limiter_mode;
  logic [slu_pkg::EPS_WIDTH-1:0]   epsilon;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limiter_mode <= slu_pkg::MODE_MINMOD_R;
      epsilon      <= slu_pkg::EPS_WIDTH'(1);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        slu_pkg::REG_MODE: limiter_mode <= slu_pkg::mode_t'(cfg.data[slu_pkg::MODE_WIDTH-1:0]);
        slu_pkg::REG_EPS:  epsilon      <= cfg.data[slu_pkg::EPS_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  logic           cv [QB+1];
  logic           cr [QB+1];
  slu_pkg::cell_t cd [QB+1];

  slu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .mode      (limiter_mode),
    .eps       (epsilon),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .a         (item.first_value),
    .b         (item.second_value),
    .out_valid (cv[0]),
    .out_ready (cr[0]),
    .out_data  (cd[0])
  );

  for (genvar i = 0; i < QB; i++) begin : g_cell
    slu_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cv[i]),
      .in_ready  (cr[i]),
      .in_data   (cd[i]),
      .out_valid (cv[i+1]),
      .out_ready (cr[i+1]),
      .out_data  (cd[i+1])
    );
  end

  logic          ov;
  logic          ld_o;
  slu_pkg::res_t ores, ores_next;

  assign ld_o   = !ov || result.ready;
  assign cr[QB] = ld_o;

  always_comb begin
    if (cd[QB].fixed) begin
      ores_next.value  = cd[QB].fval;
      ores_next.status = cd[QB].fst;
    end else begin
      ores_next = slu_pkg::emit(cd[QB].neg, EW'(cd[QB].quo));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) ov <= 1'b0;
    else if (ld_o) ov <= cv[QB];
  end

  always_ff @(posedge clk) begin
    if (ld_o) ores <= ores_next;
  end

  assign result.valid         = ov;
  assign result.limited_value = ores.value;
  assign result.status        = ores.status;

endmodule
`default_nettype wire

@@ src/slu_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// slu_checker: port checks for the slope limiter
// Watches the result channel over time and is bound to the top level.
// ----------------------------------------------------------------------------
module slu_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic [slu_pkg::DATA_WIDTH-1:0]   limited_value,
  input wire logic [slu_pkg::ST_WIDTH-1:0]     status
);

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(limited_value) && $stable(status))
    else $error("stalled result changed");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown straight after reset");

  a_zdiv_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == slu_pkg::ST_ZDIV |-> limited_value == '0)
    else $error("zero divisor with nonzero value");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == slu_pkg::ST_OK || status == slu_pkg::ST_SAT ||
                  status == slu_pkg::ST_ZDIV)
    else $error("unknown status code");

endmodule

bind slope_limiter_unit_core slu_checker u_slu_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .limited_value (result.limited_value),
  .status        (result.status)
);
`default_nettype wire

@@ bench/slu_tb_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// slu_tb_if: bench-side channel helpers
// The channel interfaces come with the block; this file holds the bench's own
// request record type used by the stimulus table.
// ----------------------------------------------------------------------------
package slu_tb_pkg;
  import slu_pkg::*;

  typedef struct {
    logic signed [DATA_WIDTH-1:0] a;
    logic signed [DATA_WIDTH-1:0] b;
    logic                         known;
    logic signed [DATA_WIDTH-1:0] val;
    logic [ST_WIDTH-1:0]          st;
  } stim_row_t;
endpackage
`default_nettype wire

@@ bench/tb_slope_limiter_unit_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb_slope_limiter_unit_core: self-checking bench for the slope limiter
// Walks a directed table in the reset form and extremes in each limiter form,
// then random requests with random idling on both sides and one long result
// hold-off; every result is compared against a bit-exact limiter predictor.
// ----------------------------------------------------------------------------
module tb_slope_limiter_unit_core;
  import slu_pkg::*;
  import slu_tb_pkg::*;

  localparam int LATENCY = 22;
  localparam int NRAND   = 136;

  typedef struct {
    logic signed [DATA_WIDTH-1:0] val;
    logic [ST_WIDTH-1:0]          st;
  } lim_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  slu_in_if  item();
  slu_out_if result();
  slu_cfg_if cfg();

  slope_limiter_unit_core DUT (
    .clk(clk), .rst(rst), .item(item.sink), .result(result.source), .cfg(cfg.sink)
  );

  always #5 clk = ~clk;

  mode_t           cur_mode;
  logic [16:0]     cur_eps;
  lim_res_t        pending_q[$];
  int              mismatches;
  int              checked;
  int              sent;
  bit              sink_idle_on;
  bit              hold_off;

  function automatic lim_res_t saturate(input bit neg, input logic [127:0] m);
    lim_res_t r;
    r.st = ST_OK;
    if (!neg) begin
      if (m > 128'h7FFF_FFFF) begin
        r.val = 32'h7FFF_FFFF;
        r.st  = ST_SAT;
      end else r.val = m[31:0];
    end else begin
      if (m > 128'h8000_0000) begin
        r.val = 32'h8000_0000;
        r.st  = ST_SAT;
      end else r.val = -m[31:0];
    end
    return r;
  endfunction

  function automatic lim_res_t limit(input logic signed [31:0] a,
                                     input logic signed [31:0] b);
    logic [127:0] ma, mb, num, den, one, ef, p;
    bit an, bn;
    lim_res_t r;
    an  = a[31];
    bn  = b[31];
    ma  = an ? 128'(-{1'b0, a} & 33'h1_FFFF_FFFF) : 128'(a[31:0]);
    mb  = bn ? 128'(-{1'b0, b} & 33'h1_FFFF_FFFF) : 128'(b[31:0]);
    ma  = ma & 128'hFFFF_FFFF;
    mb  = mb & 128'hFFFF_FFFF;
    one = 128'(1) << FRAC_BITS;
    r.st = ST_OK;
    case (cur_mode)
      MODE_ONE: r = saturate(0, one);
      MODE_VANALB_R: begin
        num = (2 * ma) << (2 * FRAC_BITS);
        den = (128'(1) << (2 * FRAC_BITS)) + ma * ma;
        r = saturate(an, num / den);
      end
      MODE_HKOREN: begin
        num = (3 * ma) << (2 * FRAC_BITS);
        den = ((ma * ma) << 1) + (128'(1) << (2 * FRAC_BITS + 1));
        den = an ? den + (ma << FRAC_BITS) : den - (ma << FRAC_BITS);
        r = saturate(an, num / den);
      end
      MODE_MINMOD_R: r = an ? saturate(0, 0) : saturate(0, (ma > one) ? one : ma);
      MODE_VANLEER: begin
        if (an || ma == 0) r = saturate(0, 0);
        else r = saturate(0, ((2 * ma) << FRAC_BITS) / (one + ma));
      end
      MODE_MIN: r.val = (a < b) ? a : b;
      MODE_MINMOD_AB: begin
        if (ma != 0 && mb != 0 && an != bn) r.val = '0;
        else r.val = (ma <= mb) ? a : b;
      end
      default: begin
        ef  = 128'(cur_eps) << FRAC_BITS;
        p   = (ma * mb) << 1;
        den = ma * ma + mb * mb + ef;
        if (den == 0) begin
          r.val = '0;
          r.st  = ST_ZDIV;
        end else if (ma != 0 && mb != 0 && an != bn) begin
          if (p >= ef) r = saturate(0, 0);
          else r = saturate(0, ((ef - p) << FRAC_BITS) / den);
        end else r = saturate(0, ((ef + p) << FRAC_BITS) / den);
      end
    endcase
    return r;
  endfunction

  task automatic send_request(input logic signed [31:0] a, input logic signed [31:0] b,
                              input bit gaps);
    if (gaps && $urandom_range(0, 7) == 0) begin
      item.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    item.valid        <= 1'b1;
    item.first_value  <= a;
    item.second_value <= b;
    do @(posedge clk); while (!item.ready);
    pending_q.push_back(limit(a, b));
    sent++;
  endtask

  task automatic end_burst();
    item.valid <= 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= d;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (idx == REG_MODE) cur_mode = mode_t'(d[2:0]);
    else if (idx == REG_EPS) cur_eps = d[16:0];
  endtask

  task automatic drain();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 3) == 0 ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      1: return $signed(32'($urandom_range(0, 'h4_0000)) - 32'h2_0000);
      2: return $signed(32'($urandom_range(0, 8)) - 32'd4);
      3: return $signed(32'($urandom_range(0, 'h800)) << $urandom_range(0, 20));
      default: return $signed(32'($urandom));
    endcase
  endfunction

  // result side: random stalls, one long hold-off, compare oldest prediction
  initial begin
    int gap;
    result.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (result.valid && result.ready) begin
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", result.limited_value);
        end else begin
          lim_res_t e;
          e = pending_q.pop_front();
          checked++;
          if (e.val !== result.limited_value || e.st !== result.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: mode %0d expected %h/%0d got %h/%0d", cur_mode,
                       e.val, e.st, result.limited_value, result.status);
          end
        end
      end
      if (hold_off) begin
        result.ready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
        result.ready <= 1'b1;
      end else if (sink_idle_on && $urandom_range(0, 9) == 0) begin
        result.ready <= 1'b0;
        gap = $urandom_range(1, 12);
        repeat (gap) @(posedge clk);
        // keep checking on the edge that re-opens
        result.ready <= 1'b1;
      end else result.ready <= 1'b1;
    end
  end

  initial begin
    stim_row_t rows[$];
    mode_t m;
    int i;
    item.valid = 1'b0;
    item.first_value = '0;
    item.second_value = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    cur_mode = MODE_MINMOD_R;
    cur_eps = 17'd1;
    mismatches = 0;
    checked = 0;
    sent = 0;
    sink_idle_on = 1'b0;
    hold_off = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset mode is minmod of r
    rows = '{
      '{32'sh0000_8000, 32'sh0, 1'b1, 32'sh0000_8000, ST_OK},
      '{32'sh7FFF_FFFF, 32'sh0, 1'b1, 32'sh0001_0000, ST_OK},
      '{32'sh8000_0000, 32'sh0, 1'b1, 32'sh0, ST_OK},
      '{32'sh0, 32'sh7FFF_FFFF, 1'b1, 32'sh0, ST_OK}
    };
    foreach (rows[k]) begin
      send_request(rows[k].a, rows[k].b, 0);
      if (rows[k].known && (pending_q[$].val !== rows[k].val || pending_q[$].st !== rows[k].st))
        $display("directed row %0d disagrees with predictor", k);
    end
    end_burst();
    drain();
    // each form at the extremes, with eps zero for the divide-by-zero case
    write_reg(REG_EPS, 32'd0);
    for (i = 0; i < 8; i++) begin
      write_reg(REG_MODE, 32'(i));
      send_request(32'sh7FFF_FFFF, 32'sh8000_0000, 0);
      send_request(32'sh8000_0000, 32'sh8000_0000, 0);
      send_request(32'sh0, 32'sh0, 0);
      end_burst();
      drain();
    end
    write_reg(REG_EPS, 32'hFFFF_FFFF);
    send_request(32'sh0, 32'sh0, 0);
    send_request(32'sh0001_0000, 32'shFFFF_0000, 0);
    end_burst();
    drain();
    write_reg(4'd9, 32'd5);

    sink_idle_on = 1'b1;
    for (int ph = 0; ph < 9; ph++) begin
      m = mode_t'($urandom_range(0, 7));
      write_reg(REG_MODE, 32'(m));
      write_reg(REG_EPS, ph == 0 ? 32'd0 : ph == 1 ? 32'd65536 :
                         32'($urandom_range(0, 'h1_FFFF)));
      if (ph == 2) hold_off = 1'b1;
      if (ph == 8) sink_idle_on = 1'b0;
      for (i = 0; i < NRAND; i++) send_request(rand_val(), rand_val(), ph != 8);
      end_burst();
      drain();
    end
    $display("covered %0d requests, %0d results checked, all eight limiter forms",
             sent, checked);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("** slope_limiter_unit_core: PASSED **");
    end else begin
      $display("** slope_limiter_unit_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("** slope_limiter_unit_core: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire
